>>> rtl/rle_sprite_scaled_rect_emitter_macros.svh
// Assertion macros for the RLE sprite rectangle emitter.
// Included by files that check their own logic; needs nothing else.
`ifndef RLE_SPRITE_SCALED_RECT_EMITTER_MACROS_SVH
`define RLE_SPRITE_SCALED_RECT_EMITTER_MACROS_SVH

// Implication checked in the same cycle.
`define RSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle.
`define RSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/rse_pkg.sv
// Shared constants, types and codes of the RLE sprite rectangle emitter.
// Depends on nothing; used by every RTL module of the block.
`default_nettype none

package rse_pkg;

  // Fixed design limits and scale factor.
  localparam int unsigned MAX_SPRITE_WIDTH  = 256;
  localparam int unsigned MAX_SPRITE_HEIGHT = 64;
  localparam int unsigned MAX_CANVAS        = 1024;
  localparam int unsigned SCALE             = 3;
  localparam int unsigned JOB_DEPTH         = 2;

  // Port widths.
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CFG_SW_W   = 9;
  localparam int unsigned CFG_SH_W   = 7;
  localparam int unsigned CFG_CV_W   = 11;
  localparam int unsigned CFG_VOFF_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RX_W       = 10;
  localparam int unsigned RY_W       = 10;
  localparam int unsigned RW_W       = 11;
  localparam int unsigned RH_W       = 2;

  // Internal widths.
  localparam int unsigned SW_W    = $clog2(MAX_SPRITE_WIDTH + 1);
  localparam int unsigned SH_W    = $clog2(MAX_SPRITE_HEIGHT + 1);
  localparam int unsigned CV_W    = $clog2(MAX_CANVAS + 1);
  localparam int unsigned SX_W    = (MAX_SPRITE_WIDTH > 1) ? $clog2(MAX_SPRITE_WIDTH) : 1;
  localparam int unsigned SY_W    = (MAX_SPRITE_HEIGHT > 1) ? $clog2(MAX_SPRITE_HEIGHT) : 1;
  localparam int unsigned TOTAL_W = $clog2(MAX_SPRITE_WIDTH * MAX_SPRITE_HEIGHT + 1);
  localparam int unsigned POS_W   = 15;
  localparam int unsigned LEFT_W  = 13;
  localparam int unsigned TOP_W   = 19;
  localparam int unsigned X_W     = 14;
  localparam int unsigned Y_W     = 20;

  // Row divider: DIV_STEP quotient bits per cycle.
  localparam int unsigned DIV_W    = 16;
  localparam int unsigned DIV_STEP = 4;
  localparam int unsigned DIV_CYC  = DIV_W / DIV_STEP;
  localparam int unsigned DIV_CNT_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int unsigned REM_W    = SW_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRITE_WIDTH      = 3'd0,
    CFG_SPRITE_HEIGHT     = 3'd1,
    CFG_CANVAS_WIDTH      = 3'd2,
    CFG_CANVAS_HEIGHT     = 3'd3,
    CFG_VERTICAL_OFFSET   = 3'd4,
    CFG_TRANSPARENT_COLOR = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_EVAL,
    F_DIV,
    F_PUSH
  } front_state_e;

  // Clamped and precomputed configuration.
  typedef struct packed {
    logic [SW_W-1:0]          sw;
    logic [SH_W-1:0]          sh;
    logic [CV_W-1:0]          cw;
    logic [CV_W-1:0]          ch;
    logic [TOTAL_W-1:0]       total;
    logic signed [LEFT_W-1:0] left;
    logic signed [TOP_W-1:0]  top;
    logic [COLOR_W-1:0]       key;
  } cfg_t;

  // One opaque run, already placed in source rows.
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [SX_W-1:0]    sx;
    logic [SY_W-1:0]    sy;
    logic [TOTAL_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic [RX_W-1:0]    x;
    logic [RY_W-1:0]    y;
    logic [RW_W-1:0]    w;
    logic [RH_W-1:0]    h;
    logic [COLOR_W-1:0] color;
  } rect_t;

endpackage

`default_nettype wire

>>> rtl/rse_front.sv
// Front end: accepts runs, tracks the pixel position and locates opaque runs.
// Uses rse_pkg; feeds jobs into rse_job_fifo.
`default_nettype none

module rse_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [rse_pkg::COLOR_W-1:0]  run_color_i,
  input  logic [rse_pkg::LEN_W-1:0]    run_length_i,
  input  logic                         frame_start_i,
  input  rse_pkg::cfg_t                cfg_i,
  input  logic                         job_full_i,
  output logic                         job_push_o,
  output rse_pkg::job_t                job_o
);

  localparam int unsigned DIV_W   = rse_pkg::DIV_W;
  localparam int unsigned REM_W   = rse_pkg::REM_W;
  localparam int unsigned POS_W   = rse_pkg::POS_W;
  localparam int unsigned TOTAL_W = rse_pkg::TOTAL_W;
  localparam int unsigned CNT_W   = rse_pkg::DIV_CNT_W;

  rse_pkg::front_state_e state_q, state_d;

  logic [rse_pkg::COLOR_W-1:0] color_q;
  logic [rse_pkg::LEN_W-1:0]   len_q;
  logic                        fs_q;
  logic [POS_W-1:0]            pos_q, pos_d;
  logic [DIV_W-1:0]            dvd_q, dvd_d, quo_q, quo_d;
  logic [REM_W-1:0]            rmd_q, rmd_d;
  logic [CNT_W-1:0]            cnt_q;
  logic [TOTAL_W-1:0]          count_q;

  logic [POS_W-1:0]   pos_eff;
  logic               in_range;
  logic [TOTAL_W-1:0] left_px;
  logic [TOTAL_W-1:0] count;
  logic               opaque;
  logic               div_done;

  // Run evaluation.
  always_comb begin
    pos_eff  = fs_q ? '0 : pos_q;
    in_range = 32'(pos_eff) < 32'(cfg_i.total);
    left_px  = cfg_i.total - TOTAL_W'(pos_eff);
    count    = (32'(len_q) < 32'(left_px)) ? TOTAL_W'(len_q) : left_px;
    opaque   = in_range && (count != '0) && (color_q != cfg_i.key);
  end

  // Restoring divider, DIV_STEP quotient bits per cycle: pos / sprite width.
  always_comb begin
    rmd_d = rmd_q;
    dvd_d = dvd_q;
    quo_d = quo_q;
    for (int k = 0; k < int'(rse_pkg::DIV_STEP); k++) begin
      rmd_d = {rmd_d[REM_W-2:0], dvd_d[DIV_W-1]};
      dvd_d = {dvd_d[DIV_W-2:0], 1'b0};
      if (rmd_d >= REM_W'(cfg_i.sw)) begin
        rmd_d = rmd_d - REM_W'(cfg_i.sw);
        quo_d = {quo_d[DIV_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign div_done = (cnt_q == CNT_W'(rse_pkg::DIV_CYC - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rse_pkg::F_IDLE: if (push_i) state_d = rse_pkg::F_EVAL;
      rse_pkg::F_EVAL: state_d = opaque ? rse_pkg::F_DIV : rse_pkg::F_IDLE;
      rse_pkg::F_DIV:  if (div_done) state_d = rse_pkg::F_PUSH;
      rse_pkg::F_PUSH: if (!job_full_i) state_d = rse_pkg::F_IDLE;
      default:         state_d = rse_pkg::F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    full_o     = (state_q != rse_pkg::F_IDLE);
    job_push_o = (state_q == rse_pkg::F_PUSH) && !job_full_i;
    job_o.color = color_q;
    job_o.sx    = rmd_q[rse_pkg::SX_W-1:0];
    job_o.sy    = quo_q[rse_pkg::SY_W-1:0];
    job_o.count = count_q;
  end

  // The position moves on as soon as the run is evaluated.
  always_comb begin
    pos_d = pos_q;
    if (state_q == rse_pkg::F_EVAL) begin
      pos_d = in_range ? POS_W'(32'(pos_eff) + 32'(count)) : pos_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rse_pkg::F_IDLE;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (state_q == rse_pkg::F_DIV) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rse_pkg::F_IDLE && push_i) begin
      color_q <= run_color_i;
      len_q   <= run_length_i;
      fs_q    <= frame_start_i;
    end
    if (state_q == rse_pkg::F_EVAL) begin
      dvd_q   <= DIV_W'(pos_eff);
      quo_q   <= '0;
      rmd_q   <= '0;
      count_q <= count;
    end else if (state_q == rse_pkg::F_DIV) begin
      dvd_q <= dvd_d;
      quo_q <= quo_d;
      rmd_q <= rmd_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rse_job_fifo.sv
// Short job queue between the front and back ends.
// Uses rse_pkg for the job type.
`default_nettype none

module rse_job_fifo #(
  parameter int unsigned DEPTH = rse_pkg::JOB_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rse_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output rse_pkg::job_t data_o,
  output logic          empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rse_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rse_back.sv
// Back end: walks a job one source row per cycle while its output is not stalled, and emits clipped rectangles.
// Uses rse_pkg; takes jobs from rse_job_fifo.
`default_nettype none

module rse_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rse_pkg::cfg_t               cfg_i,
  input  logic                        job_empty_i,
  input  rse_pkg::job_t               job_i,
  output logic                        job_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output rse_pkg::rect_t              rect_o,
  output logic                        last_o
);

  localparam int unsigned X_W     = rse_pkg::X_W;
  localparam int unsigned Y_W     = rse_pkg::Y_W;
  localparam int unsigned SW_W    = rse_pkg::SW_W;
  localparam int unsigned SX_W    = rse_pkg::SX_W;
  localparam int unsigned SY_W    = rse_pkg::SY_W;
  localparam int unsigned TOTAL_W = rse_pkg::TOTAL_W;

  logic                        active_q;
  logic [SX_W-1:0]             sx_q;
  logic [SY_W-1:0]             sy_q;
  logic [TOTAL_W-1:0]          rem_q;
  logic [rse_pkg::COLOR_W-1:0] color_q;
  logic                        pend_valid_q;
  rse_pkg::rect_t              pend_q;
  logic                        out_valid_q;
  rse_pkg::rect_t              out_q;
  logic                        out_last_q;

  logic [SW_W-1:0]       sw_left, piece;
  logic [TOTAL_W-1:0]    rem_next;
  logic signed [X_W-1:0] x0, x1, x0c, x1c, cw_s, w_full;
  logic signed [Y_W-1:0] y0, y1, y0c, y1c, ch_s, h_full;
  logic                  vis;
  rse_pkg::rect_t        row_rect;
  logic                  out_free, step_ok, flush, take_job, load_out;

  // Piece of the current source row and its place on the canvas.
  always_comb begin
    sw_left  = cfg_i.sw - SW_W'(sx_q);
    piece    = (rem_q < TOTAL_W'(sw_left)) ? SW_W'(rem_q) : sw_left;
    rem_next = rem_q - TOTAL_W'(piece);
    cw_s = X_W'(cfg_i.cw);
    ch_s = Y_W'(cfg_i.ch);
    x0 = X_W'(cfg_i.left) + X_W'(sx_q) * X_W'(rse_pkg::SCALE);
    x1 = x0 + X_W'(piece) * X_W'(rse_pkg::SCALE);
    y0 = Y_W'(cfg_i.top) + Y_W'(sy_q) * Y_W'(rse_pkg::SCALE);
    y1 = y0 + Y_W'(rse_pkg::SCALE);
    x0c = (x0 < 0) ? '0 : x0;
    y0c = (y0 < 0) ? '0 : y0;
    x1c = (x1 > cw_s) ? cw_s : x1;
    y1c = (y1 > ch_s) ? ch_s : y1;
    vis = (x1c > x0c) && (y1c > y0c);
    w_full = x1c - x0c;
    h_full = y1c - y0c;
    row_rect.x     = x0c[rse_pkg::RX_W-1:0];
    row_rect.y     = y0c[rse_pkg::RY_W-1:0];
    row_rect.w     = w_full[rse_pkg::RW_W-1:0];
    row_rect.h     = h_full[rse_pkg::RH_W-1:0];
    row_rect.color = color_q;
  end

  // A visible rectangle waits in the pending slot until the next visible one
  // or the end of the run shows whether it is the last of its run.
  always_comb begin
    out_free = !out_valid_q || pop_i;
    step_ok  = active_q && !(vis && pend_valid_q && !out_free);
    flush    = !active_q && pend_valid_q && out_free;
    take_job = !active_q && !pend_valid_q && !job_empty_i;
    load_out = (step_ok && vis && pend_valid_q) || flush;
  end

  assign job_pop_o = take_job;
  assign empty_o   = !out_valid_q;
  assign rect_o    = out_q;
  assign last_o    = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (take_job) begin
        active_q <= 1'b1;
      end else if (step_ok && rem_next == '0) begin
        active_q <= 1'b0;
      end
      if (step_ok && vis) begin
        pend_valid_q <= 1'b1;
      end else if (flush) begin
        pend_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_job) begin
      sx_q    <= job_i.sx;
      sy_q    <= job_i.sy;
      rem_q   <= job_i.count;
      color_q <= job_i.color;
    end else if (step_ok) begin
      sx_q  <= '0;
      sy_q  <= sy_q + SY_W'(1);
      rem_q <= rem_next;
    end
    if (load_out) begin
      out_q      <= pend_q;
      out_last_q <= flush;
    end
    if (step_ok && vis) begin
      pend_q <= row_rect;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rle_sprite_scaled_rect_emitter.sv
// RLE sprite run to scaled fill-rectangle emitter, top level.
// Uses rse_pkg, rse_front, rse_job_fifo, rse_back and the assertion macros.
//
// Usage: runs (color, length, frame_start) enter through a queue-style port:
// an item is taken on a clock edge with push high and full low. Rectangles
// leave through a second queue-style port: the oldest one sits on the rect_*
// ports while empty is low and is taken on an edge with pop high.
// Configuration is to be written through cfg_we_i / cfg_index_i / cfg_wdata_i
// by the user only while the block is idle; the block does not enforce this.
// Indexes past the register list are ignored. The front end evaluates each
// run and drops an empty, transparent or out-of-sprite one; an opaque run
// goes through the row/column divider (4 quotient bits per cycle) and is
// handed on as a job. Full stays high until the front end is done with a run.
// The back end takes a job, walks its source rows and then closes the run.
// A job queue of JOB_DEPTH entries sits between the two ends. When the
// receiver stalls, the back end stops and the queue fills, after which full
// stays high. Reset clears the pixel position, the queues and the registers
// to their defaults (sprite 1x1, canvas 320x240, offset 0, key color 0).
`default_nettype none
`include "rle_sprite_scaled_rect_emitter_macros.svh"

module rle_sprite_scaled_rect_emitter #(
  parameter int unsigned JOB_DEPTH = rse_pkg::JOB_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rse_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic [rse_pkg::COLOR_W-1:0]    run_color_i,
  input  logic [rse_pkg::LEN_W-1:0]      run_length_i,
  input  logic                           frame_start_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [rse_pkg::RX_W-1:0]       rect_x_o,
  output logic [rse_pkg::RY_W-1:0]       rect_y_o,
  output logic [rse_pkg::RW_W-1:0]       rect_width_o,
  output logic [rse_pkg::RH_W-1:0]       rect_height_o,
  output logic [rse_pkg::COLOR_W-1:0]    rect_color_o,
  output logic                           last_of_run_o
);

  localparam int unsigned SW_W   = rse_pkg::SW_W;
  localparam int unsigned SH_W   = rse_pkg::SH_W;
  localparam int unsigned CV_W   = rse_pkg::CV_W;
  localparam int unsigned LEFT_W = rse_pkg::LEFT_W;
  localparam int unsigned TOP_W  = rse_pkg::TOP_W;
  localparam int unsigned VOFF_W = rse_pkg::CFG_VOFF_W;

  logic [rse_pkg::CFG_SW_W-1:0] sprite_width_q;
  logic [rse_pkg::CFG_SH_W-1:0] sprite_height_q;
  logic [rse_pkg::CFG_CV_W-1:0] canvas_width_q;
  logic [rse_pkg::CFG_CV_W-1:0] canvas_height_q;
  logic [VOFF_W-1:0]            vertical_offset_q;
  logic [rse_pkg::COLOR_W-1:0]  transparent_color_q;

  rse_pkg::cfg_t       cfg_d, cfg_q;
  logic [LEFT_W-1:0]   span, span_adj;
  rse_pkg::job_t       fe_job, be_job;
  logic                job_push, job_full, job_pop, job_empty;
  rse_pkg::rect_t      rect;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sprite_width_q      <= rse_pkg::CFG_SW_W'(1);
      sprite_height_q     <= rse_pkg::CFG_SH_W'(1);
      canvas_width_q      <= rse_pkg::CFG_CV_W'(320);
      canvas_height_q     <= rse_pkg::CFG_CV_W'(240);
      vertical_offset_q   <= '0;
      transparent_color_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rse_pkg::CFG_SPRITE_WIDTH:
          sprite_width_q <= cfg_wdata_i[rse_pkg::CFG_SW_W-1:0];
        rse_pkg::CFG_SPRITE_HEIGHT:
          sprite_height_q <= cfg_wdata_i[rse_pkg::CFG_SH_W-1:0];
        rse_pkg::CFG_CANVAS_WIDTH:
          canvas_width_q <= cfg_wdata_i[rse_pkg::CFG_CV_W-1:0];
        rse_pkg::CFG_CANVAS_HEIGHT:
          canvas_height_q <= cfg_wdata_i[rse_pkg::CFG_CV_W-1:0];
        rse_pkg::CFG_VERTICAL_OFFSET:
          vertical_offset_q <= cfg_wdata_i[VOFF_W-1:0];
        rse_pkg::CFG_TRANSPARENT_COLOR:
          transparent_color_q <= cfg_wdata_i[rse_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes, pixel count and the sprite's placement on the canvas.
  always_comb begin
    if (sprite_width_q == '0) begin
      cfg_d.sw = SW_W'(1);
    end else if (32'(sprite_width_q) > rse_pkg::MAX_SPRITE_WIDTH) begin
      cfg_d.sw = SW_W'(rse_pkg::MAX_SPRITE_WIDTH);
    end else begin
      cfg_d.sw = SW_W'(sprite_width_q);
    end
    if (sprite_height_q == '0) begin
      cfg_d.sh = SH_W'(1);
    end else if (32'(sprite_height_q) > rse_pkg::MAX_SPRITE_HEIGHT) begin
      cfg_d.sh = SH_W'(rse_pkg::MAX_SPRITE_HEIGHT);
    end else begin
      cfg_d.sh = SH_W'(sprite_height_q);
    end
    if (canvas_width_q == '0) begin
      cfg_d.cw = CV_W'(1);
    end else if (32'(canvas_width_q) > rse_pkg::MAX_CANVAS) begin
      cfg_d.cw = CV_W'(rse_pkg::MAX_CANVAS);
    end else begin
      cfg_d.cw = CV_W'(canvas_width_q);
    end
    if (canvas_height_q == '0) begin
      cfg_d.ch = CV_W'(1);
    end else if (32'(canvas_height_q) > rse_pkg::MAX_CANVAS) begin
      cfg_d.ch = CV_W'(rse_pkg::MAX_CANVAS);
    end else begin
      cfg_d.ch = CV_W'(canvas_height_q);
    end
    cfg_d.total = rse_pkg::TOTAL_W'(cfg_d.sw) * rse_pkg::TOTAL_W'(cfg_d.sh);
    // Halving that rounds toward zero: add one to negative values first.
    span     = LEFT_W'(cfg_d.cw) - LEFT_W'(cfg_d.sw) * LEFT_W'(rse_pkg::SCALE);
    span_adj = span + LEFT_W'(span[LEFT_W-1]);
    cfg_d.left = {span_adj[LEFT_W-1], span_adj[LEFT_W-1:1]};
    cfg_d.top  = TOP_W'(cfg_d.ch)
               + {{(TOP_W - VOFF_W){vertical_offset_q[VOFF_W-1]}}, vertical_offset_q}
               - TOP_W'(cfg_d.sh) * TOP_W'(rse_pkg::SCALE);
    cfg_d.key  = transparent_color_q;
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  rse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .run_color_i   (run_color_i),
    .run_length_i  (run_length_i),
    .frame_start_i (frame_start_i),
    .cfg_i         (cfg_q),
    .job_full_i    (job_full),
    .job_push_o    (job_push),
    .job_o         (fe_job)
  );

  rse_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (fe_job),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (be_job),
    .empty_o (job_empty)
  );

  rse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_empty_i (job_empty),
    .job_i       (be_job),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .rect_o      (rect),
    .last_o      (last_of_run_o)
  );

  assign rect_x_o      = rect.x;
  assign rect_y_o      = rect.y;
  assign rect_width_o  = rect.w;
  assign rect_height_o = rect.h;
  assign rect_color_o  = rect.color;

  // The front end never hands a job to a full queue.
  `RSE_ASSERT_NOW(a_no_job_overflow, clk_i, rst_ni, job_push, !job_full)
  // A taken run keeps the front end busy in the following cycle.
  `RSE_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, push && !full, full)
  // Every rectangle shown has a real area.
  `RSE_ASSERT_NOW(a_rect_nonempty, clk_i, rst_ni, !empty,
                  rect_width_o != '0 && rect_height_o != '0)

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RLE sprite rectangle emitter: directed and random runs.
// Depends on rse_pkg and rle_sprite_scaled_rect_emitter, and so on the rest of its RTL.
module tb;

  localparam int PIX_SCALE     = rse_pkg::SCALE;
  localparam int RECT_CAP      = 64;
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int RUNS_TOTAL    = 480;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic [rse_pkg::COLOR_W-1:0] color;
    logic [rse_pkg::LEN_W-1:0]   len;
    logic                        fs;
    bit                          hold;
  } run_item_t;

  typedef struct {
    logic [rse_pkg::RX_W-1:0]    x;
    logic [rse_pkg::RY_W-1:0]    y;
    logic [rse_pkg::RW_W-1:0]    w;
    logic [rse_pkg::RH_W-1:0]    h;
    logic [rse_pkg::COLOR_W-1:0] color;
    logic                        last;
  } rect_exp_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [rse_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [rse_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                           push          = 1'b0;
  logic                           full;
  logic [rse_pkg::COLOR_W-1:0]    run_color_i   = '0;
  logic [rse_pkg::LEN_W-1:0]      run_length_i  = '0;
  logic                           frame_start_i = 1'b0;
  logic                           empty;
  logic                           pop           = 1'b0;
  logic [rse_pkg::RX_W-1:0]       rect_x_o;
  logic [rse_pkg::RY_W-1:0]       rect_y_o;
  logic [rse_pkg::RW_W-1:0]       rect_width_o;
  logic [rse_pkg::RH_W-1:0]       rect_height_o;
  logic [rse_pkg::COLOR_W-1:0]    rect_color_o;
  logic                           last_of_run_o;

  rle_sprite_scaled_rect_emitter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .run_color_i   (run_color_i),
    .run_length_i  (run_length_i),
    .frame_start_i (frame_start_i),
    .empty         (empty),
    .pop           (pop),
    .rect_x_o      (rect_x_o),
    .rect_y_o      (rect_y_o),
    .rect_width_o  (rect_width_o),
    .rect_height_o (rect_height_o),
    .rect_color_o  (rect_color_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the register file and the running pixel position.
  logic [rse_pkg::CFG_SW_W-1:0]          sw_reg   = 9'd1;
  logic [rse_pkg::CFG_SH_W-1:0]          sh_reg   = 7'd1;
  logic [rse_pkg::CFG_CV_W-1:0]          cw_reg   = 11'd320;
  logic [rse_pkg::CFG_CV_W-1:0]          ch_reg   = 11'd240;
  logic signed [rse_pkg::CFG_VOFF_W-1:0] voff_reg = '0;
  logic [rse_pkg::COLOR_W-1:0]           key_reg  = '0;
  logic [rse_pkg::POS_W-1:0]             pix_pos  = '0;

  run_item_t run_q[$];
  rect_exp_t rects_due[$];
  run_item_t cur_run;

  bit in_busy    = 1'b0;
  bit run_taken  = 1'b0;
  bit rect_taken = 1'b0;
  int in_gap     = 0;
  int out_gap    = 0;
  int in_mode    = 1;
  int out_mode   = 1;
  int idle_cycles   = 0;
  int runs_queued   = 0;
  int runs_taken    = 0;
  int rects_checked = 0;
  int settings_used = 0;
  int fail_count    = 0;

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int draw_gap(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
    return $urandom_range(0, 4);
  endfunction

  // Splits one accepted run into per-row rectangles and queues the visible ones.
  function automatic void place_run_rects(input logic [rse_pkg::COLOR_W-1:0] color,
                                          input logic [rse_pkg::LEN_W-1:0] len,
                                          input logic fs);
    int sw, sh, cw, ch, total, cnt, left, top, idx, remaining, sy, sx, piece;
    int x0, y0, x1, y1;
    rect_exp_t row_rects[$];
    rect_exp_t r;
    sw = clamp_dim(int'(sw_reg), rse_pkg::MAX_SPRITE_WIDTH);
    sh = clamp_dim(int'(sh_reg), rse_pkg::MAX_SPRITE_HEIGHT);
    cw = clamp_dim(int'(cw_reg), rse_pkg::MAX_CANVAS);
    ch = clamp_dim(int'(ch_reg), rse_pkg::MAX_CANVAS);
    total = sw * sh;
    if (fs) pix_pos = '0;
    if (int'(pix_pos) >= total) return;
    cnt = total - int'(pix_pos);
    if (int'(len) < cnt) cnt = int'(len);
    if (cnt == 0) return;
    if (color != key_reg) begin
      // Integer division of a signed int truncates toward zero, as the block does.
      left = (cw - sw * PIX_SCALE) / 2;
      top = ch + int'(voff_reg) - sh * PIX_SCALE;
      idx = int'(pix_pos);
      remaining = cnt;
      while (remaining > 0) begin
        sy = idx / sw;
        sx = idx - sy * sw;
        piece = sw - sx;
        if (remaining < piece) piece = remaining;
        x0 = left + sx * PIX_SCALE;
        y0 = top + sy * PIX_SCALE;
        x1 = x0 + piece * PIX_SCALE;
        y1 = y0 + PIX_SCALE;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > cw) x1 = cw;
        if (y1 > ch) y1 = ch;
        if (x1 > x0 && y1 > y0 && row_rects.size() < RECT_CAP) begin
          r.x = rse_pkg::RX_W'(x0);
          r.y = rse_pkg::RY_W'(y0);
          r.w = rse_pkg::RW_W'(x1 - x0);
          r.h = rse_pkg::RH_W'(y1 - y0);
          r.color = color;
          r.last = 1'b0;
          row_rects.push_back(r);
        end
        idx += piece;
        remaining -= piece;
      end
      if (row_rects.size() > 0) row_rects[row_rects.size() - 1].last = 1'b1;
      foreach (row_rects[i]) rects_due.push_back(row_rects[i]);
    end
    pix_pos = pix_pos + rse_pkg::POS_W'(cnt);
  endfunction

  // Acceptance on both ports, result checking and the progress watchdog.
  always @(posedge clk_i) begin : check_side
    bit moved;
    rect_exp_t want;
    moved = 1'b0;
    if (rst_ni) begin
      if (push && !full) begin
        place_run_rects(run_color_i, run_length_i, frame_start_i);
        run_taken = 1'b1;
        runs_taken++;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        rect_taken = 1'b1;
        rects_checked++;
        moved = 1'b1;
        if (rects_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected rectangle x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                     rect_x_o, rect_y_o, rect_width_o, rect_height_o, rect_color_o,
                     last_of_run_o);
        end else begin
          want = rects_due.pop_front();
          if (want.x !== rect_x_o || want.y !== rect_y_o || want.w !== rect_width_o ||
              want.h !== rect_height_o || want.color !== rect_color_o ||
              want.last !== last_of_run_o) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("rectangle mismatch: expected x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                       want.x, want.y, want.w, want.h, want.color, want.last);
              $display("                    got      x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                       rect_x_o, rect_y_o, rect_width_o, rect_height_o, rect_color_o,
                       last_of_run_o);
            end
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d rectangles outstanding",
                 idle_cycles, rects_due.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Run sender: takes items from run_q, with random gaps between them.
  always @(negedge clk_i) begin : run_driver
    if (rst_ni) begin
      if (run_taken) begin
        run_taken = 1'b0;
        in_busy = 1'b0;
        in_gap = draw_gap(in_mode);
      end
      if ($urandom_range(0, 199) == 0) in_mode = $urandom_range(0, 2);
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (run_q.size() > 0 && (!run_q[0].hold || rects_due.size() == 0)) begin
          // A held item waits until every rectangle expected so far has been drained.
          cur_run = run_q.pop_front();
          in_busy = 1'b1;
        end
      end
      push <= in_busy;
      run_color_i <= cur_run.color;
      run_length_i <= cur_run.len;
      frame_start_i <= cur_run.fs;
    end
  end

  // Rectangle receiver: pop with random stalls.
  always @(negedge clk_i) begin : rect_sink
    if (rst_ni) begin
      if (rect_taken) begin
        rect_taken = 1'b0;
        out_gap = draw_gap(out_mode);
      end
      if ($urandom_range(0, 199) == 0) out_mode = $urandom_range(0, 2);
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic add_run(input logic [rse_pkg::COLOR_W-1:0] color,
                         input logic [rse_pkg::LEN_W-1:0] len,
                         input logic fs, input bit hold);
    run_item_t it;
    it.color = color;
    it.len = len;
    it.fs = fs;
    it.hold = hold;
    run_q.push_back(it);
    runs_queued++;
  endtask

  task automatic write_reg(input rse_pkg::cfg_idx_e idx,
                           input logic [rse_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      rse_pkg::CFG_SPRITE_WIDTH:      sw_reg = data[rse_pkg::CFG_SW_W-1:0];
      rse_pkg::CFG_SPRITE_HEIGHT:     sh_reg = data[rse_pkg::CFG_SH_W-1:0];
      rse_pkg::CFG_CANVAS_WIDTH:      cw_reg = data[rse_pkg::CFG_CV_W-1:0];
      rse_pkg::CFG_CANVAS_HEIGHT:     ch_reg = data[rse_pkg::CFG_CV_W-1:0];
      rse_pkg::CFG_VERTICAL_OFFSET:   voff_reg = data;
      rse_pkg::CFG_TRANSPARENT_COLOR: key_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] sw, input logic [15:0] sh, input logic [15:0] cw,
                           input logic [15:0] ch, input logic [15:0] voff,
                           input logic [15:0] key);
    write_reg(rse_pkg::CFG_SPRITE_WIDTH, sw);
    write_reg(rse_pkg::CFG_SPRITE_HEIGHT, sh);
    write_reg(rse_pkg::CFG_CANVAS_WIDTH, cw);
    write_reg(rse_pkg::CFG_CANVAS_HEIGHT, ch);
    write_reg(rse_pkg::CFG_VERTICAL_OFFSET, voff);
    write_reg(rse_pkg::CFG_TRANSPARENT_COLOR, key);
    settings_used++;
  endtask

  // Waits until all queued runs are taken and every rectangle has arrived, then lets
  // the pipeline drain runs that produce nothing.
  task automatic settle();
    while (run_q.size() != 0 || in_busy || rects_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int sw_v, sh_v, cw_v, ch_v, voff_v, key_v, swc, left_px, phase_end, len, span;
    logic [15:0] palette[4];
    logic [15:0] color;
    logic [15:0] junk;
    logic fs;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: a 1x1 sprite on a 320x240 canvas, key color zero.
    add_run(16'h0000, 16'd1, 1'b1, 1'b0);
    add_run(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    add_run(16'h1234, 16'd5, 1'b0, 1'b0);
    add_run(16'h1234, 16'd0, 1'b1, 1'b0);
    settle();

    // Largest sprite on the largest canvas: a full-frame run spans every row.
    configure(16'd256, 16'd64, 16'd1024, 16'd1024, 16'd0, 16'hFFFF);
    add_run(16'h0000, 16'hFFFF, 1'b1, 1'b0);
    add_run(16'hFFFF, 16'd300, 1'b1, 1'b0);
    add_run(16'h8001, 16'd500, 1'b0, 1'b1);
    add_run(16'h7FFF, 16'd8000, 1'b0, 1'b0);
    add_run(16'h0001, 16'hFFFF, 1'b0, 1'b0);
    settle();

    // Narrow canvas: the left edge goes negative and whole row pieces get clipped.
    // The first run starts past the smaller sprite left over from the last frame.
    configure(16'd5, 16'd3, 16'd2, 16'd10, 16'hFFFE, 16'h0000);
    add_run(16'h0042, 16'd7, 1'b0, 1'b0);
    add_run(16'h0042, 16'd7, 1'b1, 1'b0);
    add_run(16'h0043, 16'd20, 1'b0, 1'b0);
    settle();

    // Out-of-range register values clamp; extreme offsets push everything off-canvas.
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFF);
    add_run(16'h0000, 16'd100, 1'b1, 1'b0);
    add_run(16'h5555, 16'hAAAA, 1'b0, 1'b0);
    settle();
    configure(16'h0000, 16'h0000, 16'h0000, 16'h07FF, 16'h8000, 16'h5555);
    add_run(16'h5555, 16'd1, 1'b1, 1'b0);
    add_run(16'hAAAA, 16'd1, 1'b1, 1'b0);
    settle();

    // Centring of an odd negative margin rounds toward zero; bottom row is cut to height 1.
    configure(16'd7, 16'd2, 16'd20, 16'd6, 16'd2, 16'h0000);
    add_run(16'h0F0F, 16'd14, 1'b1, 1'b0);
    add_run(16'h0F0F, 16'd3, 1'b1, 1'b0);
    settle();

    while (runs_queued < RUNS_TOTAL) begin
      case ($urandom_range(0, 9))
        0: sw_v = 256;
        1: sw_v = 0;
        2: sw_v = $urandom_range(257, 511);
        3: sw_v = $urandom_range(1, 256);
        default: sw_v = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 9))
        0: sh_v = 64;
        1: sh_v = 0;
        2: sh_v = $urandom_range(65, 127);
        default: sh_v = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
        0: cw_v = 1024;
        1: cw_v = 0;
        2: cw_v = $urandom_range(1025, 2047);
        3: cw_v = $urandom_range(1, 40);
        default: cw_v = $urandom_range(1, 1024);
      endcase
      case ($urandom_range(0, 9))
        0: ch_v = 1024;
        1: ch_v = 0;
        2: ch_v = $urandom_range(1025, 2047);
        3: ch_v = $urandom_range(1, 40);
        default: ch_v = $urandom_range(1, 1024);
      endcase
      case ($urandom_range(0, 9))
        0: voff_v = 32767;
        1: voff_v = -32768;
        2: voff_v = int'($urandom_range(0, 65535)) - 32768;
        default: voff_v = int'($urandom_range(0, 200)) - 100;
      endcase
      foreach (palette[i]) palette[i] = 16'($urandom);
      key_v = ($urandom_range(0, 9) < 7) ? int'(palette[0]) : int'($urandom_range(0, 65535));
      // Now and then the unused upper bits of the narrow registers carry junk.
      junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
      configure((junk & 16'hFE00) | 16'(sw_v), (junk & 16'hFF80) | 16'(sh_v),
                (junk & 16'hF800) | 16'(cw_v), (junk & 16'hF800) | 16'(ch_v),
                16'(voff_v), 16'(key_v));

      swc = clamp_dim(sw_v, rse_pkg::MAX_SPRITE_WIDTH);
      phase_end = runs_queued + $urandom_range(30, 45);
      while (runs_queued < phase_end) begin
        if ($urandom_range(0, 4) == 0) begin
          len = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 65535))
                                            : int'($urandom_range(0, 40));
          color = ($urandom_range(0, 3) == 0) ? palette[0] : 16'($urandom);
          add_run(color, 16'(len), 1'($urandom_range(0, 1)), $urandom_range(0, 49) == 0);
        end else begin
          // A well-formed frame, possibly cut short when the phase ends.
          left_px = swc * clamp_dim(sh_v, rse_pkg::MAX_SPRITE_HEIGHT);
          fs = 1'b1;
          while (left_px > 0 && runs_queued < phase_end) begin
            span = (left_px < 3 * swc) ? left_px : 3 * swc;
            if ($urandom_range(0, 14) == 0) len = 0;
            else if ($urandom_range(0, 9) == 0) len = left_px + $urandom_range(1, 50);
            else if ($urandom_range(0, 3) == 0) len = $urandom_range(1, left_px);
            else len = $urandom_range(1, span);
            case ($urandom_range(0, 9))
              0, 1, 2: color = 16'(key_v);
              3, 4, 5, 6: color = palette[$urandom_range(1, 3)];
              default: color = 16'($urandom);
            endcase
            add_run(color, 16'(len), fs, $urandom_range(0, 49) == 0);
            fs = 1'b0;
            left_px -= (len < left_px) ? len : left_px;
          end
        end
      end
      settle();
    end

    if (rects_due.size() != 0) fail_count += rects_due.size();
    $display("covered %0d runs across %0d register settings, %0d rectangles compared",
             runs_taken, settings_used, rects_checked);
    $display("failures found: %0d", fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/rse_pkg.sv
rtl/rse_front.sv
rtl/rse_job_fifo.sv
rtl/rse_back.sv
rtl/rle_sprite_scaled_rect_emitter.sv
tb/tb.sv
